[design/tmhe_pkg.sv]
`default_nettype none

package tmhe_pkg;

	// Fixed field widths of the stream items.
	localparam int DL_W     = 48;
	localparam int TAG_IO_W = 16;
	localparam int WAIT_W   = 32;
	localparam int CNT_W    = 6;
	localparam int IN_W     = 112;
	localparam int OUT_W    = 56;

	// Summary wait values.
	localparam logic [WAIT_W-1:0] WAIT_MAX   = 32'h7FFF_FFFF;
	localparam logic [WAIT_W-1:0] WAIT_EMPTY = 32'hFFFF_FFFF;

	// Input action codes.
	localparam logic ACT_PUSH = 1'b0;
	localparam logic ACT_TICK = 1'b1;

	// Result kinds.
	typedef enum logic [1:0] {
		KIND_ACCEPT  = 2'd0,
		KIND_FULL    = 2'd1,
		KIND_EXPIRED = 2'd2,
		KIND_SUMMARY = 2'd3
	} kind_t;

	// Controller states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PUSH_START,
		ST_PUSH_UP,
		ST_PUSH_CMP,
		ST_PUSH_EMIT,
		ST_TICK_RD,
		ST_TICK_CHK,
		ST_DN_RD,
		ST_DN_CMP
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic  load;        // capture the accepted input item
		logic  push_begin;  // hole at the heap end, grow the heap
		logic  up_place;    // write the new entry at the hole (root reached)
		logic  rd_parent;   // read the parent of the hole
		logic  up_step;     // place the new entry or move the parent down
		logic  rd_top;      // read the root and the last entry
		logic  pop_begin;   // remove the root, take the last entry as moving
		logic  rd_kids;     // read both children of the hole
		logic  dn_step;     // place the moving entry or move a child up
		logic  emit;        // load the output register
		kind_t kind;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic full;
		logic hole_zero;
		logic up_stop;
		logic expire;
		logic dn_stop;
		logic out_free;
	} status_t;

endpackage

`default_nettype wire

[design/tmhe_ctrl.sv]
`default_nettype none

module tmhe_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic             action,
	output logic                  in_ready,
	input  tmhe_pkg::status_t     status,
	output tmhe_pkg::cmd_t        cmd
);
	import tmhe_pkg::*;

	state_t state_q;
	state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		cmd.kind = KIND_ACCEPT;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = (action == ACT_TICK) ? ST_TICK_RD : ST_PUSH_START;
				end
			end
			ST_PUSH_START: begin
				if (status.full) begin
					if (status.out_free) begin
						cmd.emit = 1'b1;
						cmd.kind = KIND_FULL;
						state_d  = ST_IDLE;
					end
				end else begin
					cmd.push_begin = 1'b1;
					state_d        = ST_PUSH_UP;
				end
			end
			ST_PUSH_UP: begin
				if (status.hole_zero) begin
					cmd.up_place = 1'b1;
					state_d      = ST_PUSH_EMIT;
				end else begin
					cmd.rd_parent = 1'b1;
					state_d       = ST_PUSH_CMP;
				end
			end
			ST_PUSH_CMP: begin
				cmd.up_step = 1'b1;
				state_d     = status.up_stop ? ST_PUSH_EMIT : ST_PUSH_UP;
			end
			ST_PUSH_EMIT: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					cmd.kind = KIND_ACCEPT;
					state_d  = ST_IDLE;
				end
			end
			ST_TICK_RD: begin
				cmd.rd_top = 1'b1;
				state_d    = ST_TICK_CHK;
			end
			ST_TICK_CHK: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					if (status.expire) begin
						cmd.kind      = KIND_EXPIRED;
						cmd.pop_begin = 1'b1;
						state_d       = ST_DN_RD;
					end else begin
						cmd.kind = KIND_SUMMARY;
						state_d  = ST_IDLE;
					end
				end
			end
			ST_DN_RD: begin
				cmd.rd_kids = 1'b1;
				state_d     = ST_DN_CMP;
			end
			ST_DN_CMP: begin
				cmd.dn_step = 1'b1;
				state_d     = status.dn_stop ? ST_TICK_RD : ST_DN_RD;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

[design/tmhe_dp.sv]
`default_nettype none

module tmhe_dp #(
	parameter int HEAP_DEPTH = 32,
	parameter int TAG_WIDTH  = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic [tmhe_pkg::DL_W-1:0]       in_deadline,
	input  wire logic [tmhe_pkg::TAG_IO_W-1:0]   in_tag,
	input  wire logic [tmhe_pkg::DL_W-1:0]       in_now,
	input  tmhe_pkg::cmd_t                       cmd,
	output tmhe_pkg::status_t                    status,
	input  wire logic                            out_ready,
	output logic                                 out_valid,
	output logic [1:0]                           out_kind,
	output logic [tmhe_pkg::TAG_IO_W-1:0]        out_tag,
	output logic [tmhe_pkg::WAIT_W-1:0]          out_wait,
	output logic                                 out_work,
	output logic [tmhe_pkg::CNT_W-1:0]           out_count,
	output logic                                 out_last
);
	import tmhe_pkg::*;

	localparam int IDX_W = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;

	typedef struct packed {
		logic [DL_W-1:0]      dl;
		logic [TAG_WIDTH-1:0] tag;
	} entry_t;

	entry_t             heap_mem_q [HEAP_DEPTH];
	entry_t             rd_a_q;
	entry_t             rd_b_q;
	entry_t             cur_q;
	logic [DL_W-1:0]    now_q;
	logic [CNT_W-1:0]   size_q;
	logic [IDX_W-1:0]   hole_q;
	logic               work_q;

	logic               out_valid_q;
	kind_t              out_kind_q;
	logic [TAG_IO_W-1:0] out_tag_q;
	logic [WAIT_W-1:0]  out_wait_q;
	logic               out_work_q;
	logic [CNT_W-1:0]   out_count_q;
	logic               out_last_q;

	logic [IDX_W-1:0]   parent_idx;
	logic [CNT_W:0]     left_full;
	logic [CNT_W:0]     right_full;
	logic               left_ok;
	logic               right_ok;
	logic               take_left;
	logic               take_right;
	logic [DL_W-1:0]    best_dl;
	logic               rd_a_en;
	logic               rd_b_en;
	logic [IDX_W-1:0]   addr_a;
	logic [IDX_W-1:0]   addr_b;
	logic               wr_en;
	logic [IDX_W-1:0]   wr_addr;
	entry_t             wr_data;
	logic [DL_W-1:0]    wait_diff;
	logic [WAIT_W-1:0]  wait_val;
	logic               out_free;

	// Heap index arithmetic around the hole.
	assign parent_idx = (hole_q - IDX_W'(1)) >> 1;
	assign left_full  = ((CNT_W+1)'(hole_q) << 1) + (CNT_W+1)'(1);
	assign right_full = ((CNT_W+1)'(hole_q) << 1) + (CNT_W+1)'(2);
	assign left_ok    = left_full < (CNT_W+1)'(size_q);
	assign right_ok   = right_full < (CNT_W+1)'(size_q);

	// Sift-down choice: a child moves up only if strictly smaller, left wins ties.
	always_comb begin
		take_left  = left_ok && (rd_a_q.dl < cur_q.dl);
		best_dl    = take_left ? rd_a_q.dl : cur_q.dl;
		take_right = right_ok && (rd_b_q.dl < best_dl);
	end

	// Read port addresses.
	always_comb begin
		rd_a_en = cmd.rd_parent | cmd.rd_top | cmd.rd_kids;
		rd_b_en = cmd.rd_top | cmd.rd_kids;
		addr_a  = parent_idx;
		addr_b  = right_full[IDX_W-1:0];
		if (cmd.rd_top) begin
			addr_a = '0;
			addr_b = IDX_W'(size_q - CNT_W'(1));
		end else if (cmd.rd_kids) begin
			addr_a = left_full[IDX_W-1:0];
		end
	end

	// Write port: the hole receives either the moving entry or a neighbor.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = hole_q;
		wr_data = cur_q;
		if (cmd.up_place) begin
			wr_en = 1'b1;
		end else if (cmd.up_step) begin
			wr_en = 1'b1;
			if (!status.up_stop) begin
				wr_data = rd_a_q;
			end
		end else if (cmd.dn_step) begin
			wr_en = 1'b1;
			if (take_right) begin
				wr_data = rd_b_q;
			end else if (take_left) begin
				wr_data = rd_a_q;
			end
		end
	end

	// Heap storage with registered reads.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			heap_mem_q[wr_addr] <= wr_data;
		end
		if (rd_a_en) begin
			rd_a_q <= heap_mem_q[addr_a];
		end
		if (rd_b_en) begin
			rd_b_q <= heap_mem_q[addr_b];
		end
	end

	// Item registers and the moving entry.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cur_q.dl  <= in_deadline;
			cur_q.tag <= TAG_WIDTH'(in_tag);
			now_q     <= in_now;
			work_q    <= 1'b0;
		end else if (cmd.pop_begin) begin
			cur_q  <= rd_b_q;
			work_q <= 1'b1;
		end
	end

	// Heap size and hole position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= '0;
			hole_q <= '0;
		end else begin
			if (cmd.push_begin) begin
				hole_q <= IDX_W'(size_q);
				size_q <= size_q + CNT_W'(1);
			end else if (cmd.pop_begin) begin
				hole_q <= '0;
				size_q <= size_q - CNT_W'(1);
			end else if (cmd.up_step && !status.up_stop) begin
				hole_q <= parent_idx;
			end else if (cmd.dn_step && take_right) begin
				hole_q <= right_full[IDX_W-1:0];
			end else if (cmd.dn_step && take_left) begin
				hole_q <= left_full[IDX_W-1:0];
			end
		end
	end

	// Summary wait, saturated.
	always_comb begin
		wait_diff = rd_a_q.dl - now_q;
		if (size_q == '0) begin
			wait_val = WAIT_EMPTY;
		end else if (wait_diff > DL_W'(WAIT_MAX)) begin
			wait_val = WAIT_MAX;
		end else begin
			wait_val = wait_diff[WAIT_W-1:0];
		end
	end

	assign out_free = !out_valid_q || out_ready;

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_kind_q <= cmd.kind;
			case (cmd.kind)
				KIND_EXPIRED: begin
					out_tag_q   <= TAG_IO_W'(rd_a_q.tag);
					out_wait_q  <= '0;
					out_work_q  <= 1'b0;
					out_count_q <= size_q - CNT_W'(1);
					out_last_q  <= 1'b0;
				end
				KIND_SUMMARY: begin
					out_tag_q   <= '0;
					out_wait_q  <= wait_val;
					out_work_q  <= work_q;
					out_count_q <= size_q;
					out_last_q  <= 1'b1;
				end
				default: begin
					out_tag_q   <= '0;
					out_wait_q  <= '0;
					out_work_q  <= 1'b0;
					out_count_q <= size_q;
					out_last_q  <= 1'b1;
				end
			endcase
		end
	end

	// Status to the controller.
	always_comb begin
		status.full      = size_q == CNT_W'(HEAP_DEPTH);
		status.hole_zero = hole_q == '0;
		status.up_stop   = rd_a_q.dl <= cur_q.dl;
		status.expire    = (size_q != '0) && (rd_a_q.dl <= now_q);
		status.dn_stop   = !take_left && !take_right;
		status.out_free  = out_free;
	end

	assign out_valid = out_valid_q;
	assign out_kind  = out_kind_q;
	assign out_tag   = out_tag_q;
	assign out_wait  = out_wait_q;
	assign out_work  = out_work_q;
	assign out_count = out_count_q;
	assign out_last  = out_last_q;

endmodule

`default_nettype wire

[design/timer_min_heap_expiry.sv]
// Timer queue held as a binary min-heap of deadline and tag pairs.
// Input stream (s_*): s_tuser[0] selects push (0) or tick (1). A push stores
// deadline_ms and timer_tag and returns one result: accepted, or full when
// HEAP_DEPTH timers are already held. A tick carries now_ms; it returns one
// expired result per timer due at or before now_ms, earliest deadline first, then a
// summary with the wait to the next deadline and the did-work flag.
// Output stream (m_*): m_tuser is the result kind, m_tlast marks the final
// result of an input item.
// Items are taken one at a time; s_tready is high only while the block waits
// for a new item, which it does in the cycle after the final result of an item is loaded.
// After the accepting edge a push opens a hole at the heap end and then climbs:
// for each level it reads the parent, then compares and writes, until it stops
// or reaches the root; then its result is issued. A push into a full heap issues
// its result directly. A tick reads the root and checks it; each expired timer
// is then walked down, each level being a read of both children and then a
// compare-and-write step, and the root is checked again. These steps follow from
// the single-write, two-read heap memory.
// A result waits in the output register while m_tready is low; the block
// stalls at the next result until that register is free.
// Reset empties the heap; no clearing pass is needed.
`default_nettype none

module timer_min_heap_expiry #(
	parameter int HEAP_DEPTH = 32,
	parameter int TAG_WIDTH  = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	output logic               s_tready,
	// deadline_ms [47:0], timer_tag [63:48], now_ms [111:64]
	input  wire logic [111:0]  s_tdata,
	// action [0]
	input  wire logic [0:0]    s_tuser,
	output logic               m_tvalid,
	input  wire logic          m_tready,
	// expired_tag [15:0], next_wait_ms [47:16], did_work [48],
	// pending_count [54:49], zero [55]
	output logic [55:0]        m_tdata,
	// kind [1:0]
	output logic [1:0]         m_tuser,
	output logic               m_tlast
);
	import tmhe_pkg::*;

	cmd_t                 cmd;
	status_t              status;
	logic [TAG_IO_W-1:0]  out_tag;
	logic [WAIT_W-1:0]    out_wait;
	logic                 out_work;
	logic [CNT_W-1:0]     out_count;

	tmhe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.action   (s_tuser[0]),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	tmhe_dp #(
		.HEAP_DEPTH (HEAP_DEPTH),
		.TAG_WIDTH  (TAG_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_deadline (s_tdata[47:0]),
		.in_tag      (s_tdata[63:48]),
		.in_now      (s_tdata[111:64]),
		.cmd         (cmd),
		.status      (status),
		.out_ready   (m_tready),
		.out_valid   (m_tvalid),
		.out_kind    (m_tuser),
		.out_tag     (out_tag),
		.out_wait    (out_wait),
		.out_work    (out_work),
		.out_count   (out_count),
		.out_last    (m_tlast)
	);

	// Pack the result fields; the concatenation lists the highest field first.
	assign m_tdata = {1'b0, out_count, out_work, out_wait, out_tag};

endmodule

`default_nettype wire

[verif/tb_timer_min_heap_expiry.sv]
`timescale 1ns / 1ps

module tb_timer_min_heap_expiry;
	import tmhe_pkg::*;

	localparam int HEAP_CAP = 32;
	localparam int QUIET_LIMIT = 4000;
	localparam logic [DL_W-1:0] DL_MAX = '1;

	// One result item as the block should produce it.
	typedef struct {
		kind_t kind;
		logic [TAG_IO_W-1:0] tag;
		logic [WAIT_W-1:0] wait_ms;
		logic work;
		logic [CNT_W-1:0] held;
		logic last;
	} reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;
	logic [0:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;
	logic [1:0] m_tuser;
	logic m_tlast;

	// Shadow copy of the timer heap.
	logic [DL_W-1:0] shadow_deadline [HEAP_CAP];
	logic [TAG_IO_W-1:0] shadow_tag [HEAP_CAP];
	int shadow_count = 0;

	reply_t replies_due[$];
	int mismatch_count = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	logic [DL_W-1:0] clock_ms;

	always #1 clk = ~clk;

	timer_min_heap_expiry #(
		.HEAP_DEPTH(HEAP_CAP),
		.TAG_WIDTH(TAG_IO_W)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	function automatic logic [DL_W-1:0] rand48();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[DL_W-1:0];
	endfunction

	function automatic logic [TAG_IO_W-1:0] rand_tag();
		return TAG_IO_W'($urandom);
	endfunction

	function automatic void shadow_swap(int a, int b);
		logic [DL_W-1:0] d;
		logic [TAG_IO_W-1:0] t;
		d = shadow_deadline[a];
		t = shadow_tag[a];
		shadow_deadline[a] = shadow_deadline[b];
		shadow_tag[a] = shadow_tag[b];
		shadow_deadline[b] = d;
		shadow_tag[b] = t;
	endfunction

	// Insert at the end and climb while the parent is strictly later.
	function automatic void shadow_insert(logic [DL_W-1:0] dl, logic [TAG_IO_W-1:0] tg);
		int pos;
		int up;
		pos = shadow_count;
		shadow_deadline[pos] = dl;
		shadow_tag[pos] = tg;
		shadow_count++;
		while (pos > 0) begin
			up = (pos - 1) / 2;
			if (shadow_deadline[up] <= shadow_deadline[pos])
				break;
			shadow_swap(pos, up);
			pos = up;
		end
	endfunction

	// Remove the root; the last entry sinks toward a strictly earlier child, left first.
	function automatic logic [TAG_IO_W-1:0] shadow_take_earliest();
		logic [TAG_IO_W-1:0] top;
		int pos;
		int lc;
		int rc;
		int pick;
		top = shadow_tag[0];
		shadow_count--;
		shadow_deadline[0] = shadow_deadline[shadow_count];
		shadow_tag[0] = shadow_tag[shadow_count];
		pos = 0;
		forever begin
			lc = 2 * pos + 1;
			rc = 2 * pos + 2;
			pick = pos;
			if (lc < shadow_count && shadow_deadline[lc] < shadow_deadline[pick])
				pick = lc;
			if (rc < shadow_count && shadow_deadline[rc] < shadow_deadline[pick])
				pick = rc;
			if (pick == pos)
				break;
			shadow_swap(pos, pick);
			pos = pick;
		end
		return top;
	endfunction

	// Work out the results of one accepted item and queue them.
	function automatic void apply_timer_item(logic act, logic [DL_W-1:0] dl,
			logic [TAG_IO_W-1:0] tg, logic [DL_W-1:0] now);
		reply_t r;
		logic [DL_W-1:0] gap;
		r = '{KIND_ACCEPT, '0, '0, 1'b0, '0, 1'b1};
		if (act == ACT_PUSH) begin
			if (shadow_count >= HEAP_CAP)
				r.kind = KIND_FULL;
			else
				shadow_insert(dl, tg);
			r.held = CNT_W'(shadow_count);
			replies_due.push_back(r);
		end else begin
			// Pop every timer that is due, then summarize.
			while (shadow_count > 0 && shadow_deadline[0] <= now) begin
				r = '{KIND_EXPIRED, '0, '0, 1'b0, '0, 1'b0};
				r.tag = shadow_take_earliest();
				r.held = CNT_W'(shadow_count);
				replies_due.push_back(r);
				r.work = 1'b1;
			end
			r.kind = KIND_SUMMARY;
			r.tag = '0;
			r.last = 1'b1;
			r.held = CNT_W'(shadow_count);
			if (shadow_count == 0) begin
				r.wait_ms = WAIT_EMPTY;
			end else begin
				gap = shadow_deadline[0] - now;
				r.wait_ms = (gap > DL_W'(WAIT_MAX)) ? WAIT_MAX : gap[WAIT_W-1:0];
			end
			replies_due.push_back(r);
		end
	endfunction

	task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
		$display("%0t ns: %s: got 0x%0h, expected 0x%0h", $time, field, got, want);
		mismatch_count++;
	endtask

	// Present one item, possibly after an idle gap, and hold it until it is taken.
	task automatic send_item(logic act, logic [DL_W-1:0] dl, logic [TAG_IO_W-1:0] tg,
			logic [DL_W-1:0] now);
		bit taken;
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= {now, tg, dl};
		forever begin
			@(negedge clk);
			taken = s_tready;
			if (taken)
				apply_timer_item(act, dl, tg, now);
			@(posedge clk);
			if (taken)
				break;
		end
	endtask

	// Unused fields carry random bits so that the block is seen to ignore them.
	task automatic push_timer(logic [DL_W-1:0] dl, logic [TAG_IO_W-1:0] tg);
		send_item(ACT_PUSH, dl, tg, rand48());
	endtask

	task automatic tick_at(logic [DL_W-1:0] now);
		send_item(ACT_TICK, rand48(), rand_tag(), now);
	endtask

	// Stop sending and wait until every result is taken.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (replies_due.size() != 0);
	endtask

	// Empty ticks, extreme deadlines, equal deadlines and the saturation boundary.
	task automatic test_directed_cases();
		tick_at('0);
		tick_at(DL_MAX);
		push_timer(DL_MAX, 16'hFFFF);
		tick_at('0);
		push_timer('0, 16'h0000);
		push_timer(48'd100, 16'h0001);
		push_timer(48'd100, 16'h0002);
		push_timer(48'd100, 16'h0003);
		push_timer(48'd50, 16'h5555);
		push_timer(48'd100, 16'hAAAA);
		tick_at('0);
		tick_at(48'd100);
		push_timer(48'd2147484647, 16'h00AA);
		tick_at(48'd1000);
		tick_at(48'd999);
		tick_at(DL_MAX - 1);
		tick_at(DL_MAX);
		drain_results();
	endtask

	// Fill the heap, push into a full heap, expire part of it with a tick, refill it, then drain it with one tick.
	task automatic test_heap_full();
		logic [DL_W-1:0] base;
		base = rand48() >> 1;
		while (shadow_count < HEAP_CAP)
			push_timer(base + $urandom_range(0, 40), rand_tag());
		push_timer(rand48(), rand_tag());
		push_timer(base, rand_tag());
		tick_at(base + 20);
		while (shadow_count < HEAP_CAP)
			push_timer(base + $urandom_range(10, 60), rand_tag());
		push_timer(DL_MAX, rand_tag());
		tick_at(DL_MAX);
		drain_results();
	endtask

	// Pushes near a moving clock mixed with ticks; now and then far values.
	task automatic test_random_traffic(int count);
		int sel;
		clock_ms = rand48() >> 1;
		for (int k = 0; k < count; k++) begin
			sel = $urandom_range(99);
			if (sel < 40)
				push_timer(clock_ms + $urandom_range(0, 200), rand_tag());
			else if (sel < 50)
				push_timer(clock_ms + $urandom_range(0, 3), rand_tag());
			else if (sel < 56)
				push_timer(rand48(), rand_tag());
			else if (sel < 90) begin
				clock_ms = clock_ms + $urandom_range(0, 100);
				tick_at(clock_ms);
			end else if (sel < 96)
				tick_at(rand48());
			else
				tick_at(DL_MAX);
		end
		drain_results();
	endtask

	// The receiver stalls at random.
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Compare each result taken with the oldest expectation.
	always @(negedge clk) begin
		reply_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (replies_due.size() == 0) begin
				report_mismatch("result with nothing expected", {m_tuser, m_tdata}, 0);
			end else begin
				want = replies_due.pop_front();
				if (m_tuser !== want.kind)
					report_mismatch("kind", m_tuser, want.kind);
				if (m_tdata[15:0] !== want.tag)
					report_mismatch("expired_tag", m_tdata[15:0], want.tag);
				if (m_tdata[47:16] !== want.wait_ms)
					report_mismatch("next_wait_ms", m_tdata[47:16], want.wait_ms);
				if (m_tdata[48] !== want.work)
					report_mismatch("did_work", m_tdata[48], want.work);
				if (m_tdata[54:49] !== want.held)
					report_mismatch("pending_count", m_tdata[54:49], want.held);
				if (m_tdata[55] !== 1'b0)
					report_mismatch("pad bit", m_tdata[55], 0);
				if (m_tlast !== want.last)
					report_mismatch("last", m_tlast, want.last);
			end
		end
	end

	// End the run if nothing is taken on either side for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(negedge clk);
			if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 17;
		recv_stall_pct = 83;
		test_directed_cases();
		test_heap_full();
		test_random_traffic(100);

		send_idle_pct = 83;
		recv_stall_pct = 17;
		test_random_traffic(100);
		test_heap_full();

		send_idle_pct = 0;
		recv_stall_pct = 0;
		test_random_traffic(100);

		repeat (60) @(posedge clk);
		if (mismatch_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
